/* sv/ncm_pkg.sv */
// Shared types, constants and helper functions for the nearest palette color matcher.
// No dependencies; every other file imports this package.
package ncm_pkg;

  localparam int CACHE_SLOTS_DEF     = 256;
  localparam int PALETTE_ENTRIES_DEF = 255;
  localparam int QUEUE_DEPTH         = 2;
  localparam int DIST_W              = 18;

  localparam logic       CMD_QUERY    = 1'b0;
  localparam logic       CMD_WRITE    = 1'b1;
  localparam logic [7:0] CHAN_MASK    = 8'hF8;
  localparam int         HASH_SHIFT_A = 11;
  localparam int         HASH_SHIFT_B = 22;

  typedef struct packed {
    logic        is_write;
    logic [7:0]  entry_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] key;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic dirty;
    logic query_start;
  } back_stat_t;

  function automatic logic [23:0] slot_hash(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
    logic [23:0] k;
    k = {r & CHAN_MASK, g & CHAN_MASK, b & CHAN_MASK};
    return k ^ (k >> HASH_SHIFT_A) ^ (k >> HASH_SHIFT_B);
  endfunction

endpackage

/* sv/ncm_front.sv */
// Front part: takes input words, drops out-of-range palette writes and builds the cache key.
// Depends on ncm_pkg.
module ncm_front import ncm_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic       req_valid,
  output logic       req_ready,
  input  logic       cmd,
  input  logic [7:0] entry_index,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  q_stat_t    q_stat,
  output logic       push,
  output item_t      item
);

  logic in_range;

  assign in_range  = entry_index < 8'(PALETTE_ENTRIES);
  assign req_ready = !q_stat.full;
  assign push      = req_valid && !q_stat.full && !(cmd == CMD_WRITE && !in_range);

  always_comb begin
    item.is_write    = (cmd == CMD_WRITE);
    item.entry_index = entry_index;
    item.red         = red;
    item.green       = green;
    item.blue        = blue;
    item.key         = {red[7:3], green[7:3], blue[7:3]};
  end

endmodule

/* sv/ncm_queue.sv */
// Short queue of classified words between the front and back parts.
// Depends on ncm_pkg.
module ncm_queue import ncm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head,
  output q_stat_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         store [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head         = store[rd_ptr];
  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/ncm_dist.sv */
// Distance unit: squared Euclidean distance between the query color and one palette entry.
// Depends on ncm_pkg; used by the back part during a palette scan.
module ncm_dist import ncm_pkg::*; #(
  parameter int IDX_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              flush,
  input  logic              in_valid,
  input  logic [IDX_W-1:0]  in_idx,
  input  logic [23:0]       entry,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output logic              out_valid,
  output logic [IDX_W-1:0]  out_idx,
  output logic [DIST_W-1:0] sum
);

  logic [7:0]  dr;
  logic [7:0]  dg;
  logic [7:0]  db;
  logic [15:0] sq_r;
  logic [15:0] sq_g;
  logic [15:0] sq_b;

  assign dr = (red   > entry[23:16]) ? red   - entry[23:16] : entry[23:16] - red;
  assign dg = (green > entry[15:8])  ? green - entry[15:8]  : entry[15:8]  - green;
  assign db = (blue  > entry[7:0])   ? blue  - entry[7:0]   : entry[7:0]   - blue;

  always_ff @(posedge clk) begin
    sq_r    <= 16'(dr) * 16'(dr);
    sq_g    <= 16'(dg) * 16'(dg);
    sq_b    <= 16'(db) * 16'(db);
    out_idx <= in_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid && !flush;
    end
  end

  assign sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

endmodule

/* sv/ncm_back.sv */
// Back part: palette and cache memories, cache clearing pass, lookup and palette scan.
// Depends on ncm_pkg and ncm_dist.
module ncm_back import ncm_pkg::*; #(
  parameter int CACHE_SLOTS     = CACHE_SLOTS_DEF,
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  item_t      head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic [7:0] color_index,
  output logic       cache_hit,
  output back_stat_t stat
);

  localparam int PAW = $clog2(PALETTE_ENTRIES);
  localparam int SW  = $clog2(CACHE_SLOTS);
  localparam logic [PAW-1:0] LAST = PAW'(PALETTE_ENTRIES - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  logic [23:0] pal_mem   [PALETTE_ENTRIES];
  logic [23:0] cache_mem [CACHE_SLOTS];

  logic [1:0]        state;
  logic              dirty;
  logic [SW-1:0]     sweep_addr;
  logic [7:0]        cur_r;
  logic [7:0]        cur_g;
  logic [7:0]        cur_b;
  logic [14:0]       cur_key;
  logic [SW-1:0]     cur_slot;
  logic [23:0]       cache_q;
  logic [23:0]       pal_q;
  logic              v1;
  logic [PAW-1:0]    idx1;
  logic [PAW-1:0]    scan_addr;
  logic              issuing;
  logic [DIST_W-1:0] best;
  logic [PAW-1:0]    best_idx;

  logic              d_valid;
  logic [PAW-1:0]    d_idx;
  logic [DIST_W-1:0] d_sum;

  logic              query_start;
  logic              pal_we;
  logic              sweep_go;
  logic [SW-1:0]     head_slot;
  logic              cmp_v;
  logic              better;
  logic              finish;
  logic [PAW-1:0]    fin_idx;
  logic              hit;
  logic              c_we;
  logic [SW-1:0]     c_waddr;
  logic [23:0]       c_wdata;

  assign head_slot   = SW'(slot_hash(head.red, head.green, head.blue));
  assign pop         = (state == S_IDLE) && !q_stat.empty
                       && (head.is_write || (!dirty && !rsp_valid));
  assign query_start = pop && !head.is_write;
  assign pal_we      = pop && head.is_write;
  assign sweep_go    = (state == S_IDLE) && !q_stat.empty && !head.is_write && dirty;

  assign cmp_v   = (state == S_SCAN) && d_valid;
  assign better  = d_sum < best;
  assign finish  = cmp_v && (d_idx == LAST || d_sum == '0);
  assign fin_idx = better ? d_idx : best_idx;
  assign hit     = (state == S_LOOK) && cache_q[23] && (cache_q[22:8] == cur_key);

  assign stat.dirty       = dirty;
  assign stat.query_start = query_start;

  always_comb begin
    c_we    = 1'b0;
    c_waddr = sweep_addr;
    c_wdata = '0;
    if (state == S_SWEEP) begin
      c_we = 1'b1;
    end else if (finish) begin
      c_we    = 1'b1;
      c_waddr = cur_slot;
      c_wdata = {1'b1, cur_key, 8'(fin_idx)};
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[head.entry_index[PAW-1:0]] <= {head.red, head.green, head.blue};
    end
    pal_q <= pal_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cache_mem[c_waddr] <= c_wdata;
    end
    cache_q <= cache_mem[head_slot];
  end

  ncm_dist #(
    .IDX_W (PAW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .flush     (finish),
    .in_valid  (v1),
    .in_idx    (idx1),
    .entry     (pal_q),
    .red       (cur_r),
    .green     (cur_g),
    .blue      (cur_b),
    .out_valid (d_valid),
    .out_idx   (d_idx),
    .sum       (d_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dirty      <= 1'b1;
      sweep_addr <= '0;
      rsp_valid  <= 1'b0;
      v1         <= 1'b0;
      issuing    <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      v1   <= issuing && !finish;
      idx1 <= scan_addr;
      case (state)
        S_IDLE: begin
          if (pal_we) begin
            dirty <= 1'b1;
          end
          if (sweep_go) begin
            sweep_addr <= '0;
            state      <= S_SWEEP;
          end
          if (query_start) begin
            cur_r    <= head.red;
            cur_g    <= head.green;
            cur_b    <= head.blue;
            cur_key  <= head.key;
            cur_slot <= head_slot;
            state    <= S_LOOK;
          end
        end
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == '1) begin
            dirty <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_LOOK: begin
          if (hit) begin
            rsp_valid   <= 1'b1;
            color_index <= cache_q[7:0];
            cache_hit   <= 1'b1;
            state       <= S_IDLE;
          end else begin
            scan_addr <= '0;
            issuing   <= 1'b1;
            best      <= '1;
            best_idx  <= '0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issuing) begin
            scan_addr <= scan_addr + 1'b1;
            if (scan_addr == LAST || finish) begin
              issuing <= 1'b0;
            end
          end
          if (cmp_v && better) begin
            best     <= d_sum;
            best_idx <= d_idx;
          end
          if (finish) begin
            rsp_valid   <= 1'b1;
            color_index <= 8'(fin_idx);
            cache_hit   <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/nearest_palette_color_match_cached.sv */
// Nearest palette color match with a direct-mapped result cache.
// A palette write passes through the queue to the palette memory and gives no result word.
// A cache hit answers from the cache memory; a miss walks the palette through one distance
// unit, stopping early at a zero distance. A query leaves the queue only once the previous
// result word has been taken. After reset and after palette writes, the next query first runs
// a clearing pass over the cache memory; reset leaves the queue empty and no result pending.
module nearest_palette_color_match_cached import ncm_pkg::*; #(
  parameter int CACHE_SLOTS     = CACHE_SLOTS_DEF,
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic       cmd,
  input  logic [7:0] entry_index,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic [7:0] color_index,
  output logic       cache_hit
);

  q_stat_t    q_stat;
  back_stat_t back_stat;
  item_t      push_item;
  item_t      head;
  logic       push;
  logic       pop;

  ncm_front #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .cmd         (cmd),
    .entry_index (entry_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .q_stat      (q_stat),
    .push        (push),
    .item        (push_item)
  );

  ncm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  ncm_back #(
    .CACHE_SLOTS     (CACHE_SLOTS),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .color_index (color_index),
    .cache_hit   (cache_hit),
    .stat        (back_stat)
  );

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> color_index < 8'(PALETTE_ENTRIES))
    else $error("Result word carries a palette index out of range.");

  a_clean_cache: assert property (@(posedge clk) disable iff (rst)
    back_stat.query_start |-> !back_stat.dirty)
    else $error("Query started before the cache was cleared.");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("Word pushed into a full queue.");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("Word popped from an empty queue.");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for nearest_palette_color_match_cached.
// Depends on ncm_pkg and the RTL. It runs directed words, a palette load and random
// words through valid/ready, with random idling and one long output stall.
`timescale 1ns / 1ps

module tb_top;
  import ncm_pkg::*;

  localparam int SLOTS        = CACHE_SLOTS_DEF;
  localparam int ENTRIES      = PALETTE_ENTRIES_DEF;
  localparam int RANDOM_WORDS = 1280;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 3000;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int DIRECTED_N   = 17;

  typedef struct packed {
    logic [7:0] idx;
    logic       hit;
  } match_t;

  typedef struct packed {
    logic       c;
    logic [7:0] ix;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       typed;
    logic [7:0] eidx;
    logic       ehit;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  logic       cmd = CMD_QUERY;
  logic [7:0] entry_index = 8'd0;
  logic [7:0] red = 8'd0;
  logic [7:0] green = 8'd0;
  logic [7:0] blue = 8'd0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  logic [7:0] color_index;
  logic       cache_hit;

  logic [23:0] palette [ENTRIES];
  logic [14:0] slot_key [SLOTS];
  logic [7:0]  slot_answer [SLOTS];
  bit          slot_valid [SLOTS];
  logic [23:0] color_pool [16];

  match_t pending_matches [$];
  match_t oldest_match;
  int     mismatches = 0;
  int     cycles = 0;
  int     words_sent = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  bit     calm = 1'b0;

  row_t directed_rows [DIRECTED_N] = '{
    '{CMD_WRITE, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 1'b0},
    '{CMD_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 1'b0},
    '{CMD_QUERY, 8'd0,   8'd7,   8'd7,   8'd7,   1'b1, 8'd0, 1'b1},
    '{CMD_WRITE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 1'b0},
    '{CMD_QUERY, 8'd255, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 1'b1},
    '{CMD_WRITE, 8'd1,   8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 1'b0},
    '{CMD_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 8'd1, 1'b0},
    '{CMD_QUERY, 8'd170, 8'd248, 8'd248, 8'd248, 1'b1, 8'd1, 1'b1},
    '{CMD_QUERY, 8'd85,  8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 1'b0},
    '{CMD_WRITE, 8'd2,   8'd255, 8'd0,   8'd0,   1'b0, 8'd0, 1'b0},
    '{CMD_WRITE, 8'd3,   8'd0,   8'd255, 8'd0,   1'b0, 8'd0, 1'b0},
    '{CMD_WRITE, 8'd4,   8'd0,   8'd0,   8'd255, 1'b0, 8'd0, 1'b0},
    '{CMD_QUERY, 8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 8'd4, 1'b0},
    '{CMD_QUERY, 8'd0,   8'd255, 8'd0,   8'd0,   1'b1, 8'd2, 1'b0},
    '{CMD_QUERY, 8'd0,   8'd0,   8'd255, 8'd0,   1'b1, 8'd3, 1'b0},
    '{CMD_WRITE, 8'd5,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 1'b0},
    '{CMD_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 1'b0}
  };

  nearest_palette_color_match_cached #(
    .CACHE_SLOTS(SLOTS),
    .PALETTE_ENTRIES(ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .cmd(cmd),
    .entry_index(entry_index),
    .red(red),
    .green(green),
    .blue(blue),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .color_index(color_index),
    .cache_hit(cache_hit)
  );

  always #10 clk = ~clk;

  function automatic bit nearest_match(input logic c, input logic [7:0] ix, input logic [7:0] r,
                                       input logic [7:0] g, input logic [7:0] b,
                                       output match_t m);
    logic [23:0] k24;
    logic [23:0] folded;
    logic [14:0] k15;
    int          slot;
    int unsigned best;
    int unsigned d;
    int          dr;
    int          dg;
    int          db;
    m = '0;
    if (c == CMD_WRITE) begin
      if (ix < ENTRIES) begin
        palette[ix] = {r, g, b};
        for (int s = 0; s < SLOTS; s++) slot_valid[s] = 1'b0;
      end
      return 1'b0;
    end
    k24 = {r & CHAN_MASK, g & CHAN_MASK, b & CHAN_MASK};
    folded = k24 ^ (k24 >> HASH_SHIFT_A) ^ (k24 >> HASH_SHIFT_B);
    slot = int'(folded) & (SLOTS - 1);
    k15 = {r[7:3], g[7:3], b[7:3]};
    if (slot_valid[slot] && slot_key[slot] == k15) begin
      m.idx = slot_answer[slot];
      m.hit = 1'b1;
      return 1'b1;
    end
    best = 32'hFFFF_FFFF;
    for (int i = 0; i < ENTRIES; i++) begin
      dr = int'(r) - int'(palette[i][23:16]);
      dg = int'(g) - int'(palette[i][15:8]);
      db = int'(b) - int'(palette[i][7:0]);
      d = dr * dr + dg * dg + db * db;
      if (d < best) begin
        best = d;
        m.idx = 8'(i);
        if (d == 0) break;
      end
    end
    slot_key[slot] = k15;
    slot_answer[slot] = m.idx;
    slot_valid[slot] = 1'b1;
    m.hit = 1'b0;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] mismatch: %0s", $time, what);
  endtask

  task automatic send_word(input logic c, input logic [7:0] ix, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b,
                           input bit typed, input match_t typed_m);
    int     gap;
    match_t m;
    gap = 0;
    if (!calm) begin
      while (gap < 12 && $urandom_range(99) < 36) gap++;
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd <= c;
    entry_index <= ix;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    words_sent <= words_sent + 1;
    if (nearest_match(c, ix, r, g, b, m)) pending_matches.push_back(typed ? typed_m : m);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (!hold_done && words_sent >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= calm || ($urandom_range(99) >= 36);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_matches.size() == 0) begin
        flag_mismatch($sformatf("unexpected word index %0d hit %0b", color_index, cache_hit));
      end else begin
        oldest_match = pending_matches.pop_front();
        if (color_index !== oldest_match.idx)
          flag_mismatch($sformatf("color_index %0d, expected %0d", color_index,
                                  oldest_match.idx));
        if (cache_hit !== oldest_match.hit)
          flag_mismatch($sformatf("cache_hit %0b, expected %0b", cache_hit, oldest_match.hit));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    row_t        row;
    match_t      typed_m;
    logic [23:0] pick;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    int          kind;
    for (int s = 0; s < SLOTS; s++) slot_valid[s] = 1'b0;
    for (int e = 0; e < ENTRIES; e++) palette[e] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < DIRECTED_N; n++) begin
      row = directed_rows[n];
      typed_m.idx = row.eidx;
      typed_m.hit = row.ehit;
      send_word(row.c, row.ix, row.r, row.g, row.b, row.typed, typed_m);
    end

    // The remaining entries are loaded before any query may scan past the known ones.
    // About a quarter copy an earlier entry so that ties resolve to the lower index.
    for (int e = 6; e < ENTRIES; e++) begin
      if ($urandom_range(3) == 0) pick = palette[$urandom_range(e - 1)];
      else pick = 24'($urandom);
      send_word(CMD_WRITE, 8'(e), pick[23:16], pick[15:8], pick[7:0], 1'b0, '0);
    end
    for (int p = 0; p < 16; p++) color_pool[p] = 24'($urandom);

    typed_m = '0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm <= (n >= 600 && n < 900);
      kind = $urandom_range(99);
      if (kind < 5) begin
        pick = 24'($urandom);
        send_word(CMD_WRITE, ($urandom_range(39) == 0) ? 8'd255 : 8'($urandom_range(254)),
                  pick[23:16], pick[15:8], pick[7:0], 1'b0, typed_m);
      end else begin
        if (kind < 50) begin
          pick = color_pool[$urandom_range(15)];
          r = {pick[23:19], 3'($urandom_range(7))};
          g = {pick[15:11], 3'($urandom_range(7))};
          b = {pick[7:3], 3'($urandom_range(7))};
        end else if (kind < 60) begin
          r = $urandom_range(1) ? 8'(255 - $urandom_range(8)) : 8'($urandom_range(8));
          g = $urandom_range(1) ? 8'(255 - $urandom_range(8)) : 8'($urandom_range(8));
          b = $urandom_range(1) ? 8'(255 - $urandom_range(8)) : 8'($urandom_range(8));
        end else begin
          pick = 24'($urandom);
          r = pick[23:16];
          g = pick[15:8];
          b = pick[7:0];
          color_pool[$urandom_range(15)] = pick;
        end
        send_word(CMD_QUERY, 8'($urandom), r, g, b, 1'b0, typed_m);
      end
    end

    req_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (ENTRIES + SLOTS + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/ncm_pkg.sv
sv/ncm_front.sv
sv/ncm_queue.sv
sv/ncm_dist.sv
sv/ncm_back.sv
sv/nearest_palette_color_match_cached.sv
test/tb_top.sv
